// ===== sv/assert_macros.svh =====
// Assertion helpers for the grouper checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SKDG_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define SKDG_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/skdg_pkg.sv =====
`default_nettype none
package skdg_pkg;

  localparam int KMER_W  = 64;
  localparam int POS_W   = 32;
  localparam int SNP_W   = 8;
  localparam int ALT_W   = 2;
  localparam int FREQ_W  = 8;
  localparam int SLOT_W  = 4;
  // Group size counter: holds up to the largest allowed group size (16).
  localparam int CNT_W   = 5;
  localparam int ENTRY_W = POS_W + SNP_W + ALT_W + 2 * FREQ_W;

  localparam int CMD_Q_DEPTH = 2;
  localparam int CMD_Q_AW    = $clog2(CMD_Q_DEPTH);
  localparam int CMD_Q_CW    = $clog2(CMD_Q_DEPTH + 1);

  localparam logic ITEM_DICT = 1'b0;
  localparam logic ITEM_AUX  = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [SNP_W-1:0]  snp;
    logic [ALT_W-1:0]  alt;
    logic [FREQ_W-1:0] rf;
    logic [FREQ_W-1:0] af;
  } entry_t;

  typedef struct packed {
    logic [KMER_W-1:0] kmer;
    entry_t            entry;
    logic              final_rec;
  } in_rec_t;

  typedef enum logic [1:0] {
    CMD_UNIQUE,
    CMD_AUX,
    CMD_OVER
  } cmd_kind_t;

  // One closed group, handed from the front to the back.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [KMER_W-1:0] kmer;
    logic [POS_W-1:0]  value;
    entry_t            first;
    logic [CNT_W-1:0]  cnt;
    logic              bank;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic              item_kind;
    logic [KMER_W-1:0] kmer_key;
    logic [POS_W-1:0]  position_or_row;
    logic              is_ambiguous;
    logic [SNP_W-1:0]  snp;
    logic [ALT_W-1:0]  alt;
    logic [FREQ_W-1:0] rf;
    logic [FREQ_W-1:0] af;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } res_t;

  // Back tells the front that a group store bank is free again.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage
`default_nettype wire

// ===== sv/skdg_ram.sv =====
`default_nettype none
module skdg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/skdg_cmd_queue.sv =====
`default_nettype none
module skdg_cmd_queue import skdg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t din,
  output logic      full,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      empty
);

  cmd_t                slots [CMD_Q_DEPTH];
  logic [CMD_Q_AW-1:0] wptr;
  logic [CMD_Q_AW-1:0] rptr;
  logic [CMD_Q_CW-1:0] cnt;
  logic                do_push;
  logic                do_pop;

  assign full    = (cnt == CMD_Q_CW'(CMD_Q_DEPTH));
  assign empty   = (cnt == '0);
  assign dout    = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == CMD_Q_AW'(CMD_Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == CMD_Q_AW'(CMD_Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
    if (do_push) begin
      slots[wptr] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== sv/skdg_front.sv =====
`default_nettype none
module skdg_front import skdg_pkg::*; #(
  parameter int GROUP_SLOTS = 10,
  localparam int SLOT_AW = $clog2(GROUP_SLOTS)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire in_rec_t           in_rec,
  output logic                   full,
  input  wire logic              cfg_we,
  input  wire logic [POS_W-1:0]  cfg_wdata,
  output logic                   q_push,
  output cmd_t                   q_cmd,
  input  wire logic              q_full,
  input  wire bank_rel_t         rel,
  output logic                   ram_we,
  output logic [SLOT_AW:0]       ram_waddr,
  output logic [ENTRY_W-1:0]     ram_wdata
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_CLOSE_A,
    F_ADD,
    F_CLOSE_B
  } fstate_t;

  fstate_t           state, state_next;
  in_rec_t           hold, hold_next;
  logic              pending_valid, pending_valid_next;
  logic [KMER_W-1:0] pending_kmer, pending_kmer_next;
  entry_t            first_entry, first_entry_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              overflow, overflow_next;
  logic [POS_W-1:0]  row, row_next;
  logic              bank, bank_next;
  logic [1:0]        busy, busy_next;
  logic [POS_W-1:0]  marker;
  cmd_t              close_cmd;
  logic              do_close;
  fstate_t           after_add;

  assign full = (state != F_IDLE);

  always_comb begin
    close_cmd.kmer  = pending_kmer;
    close_cmd.first = first_entry;
    close_cmd.cnt   = count;
    close_cmd.bank  = bank;
    close_cmd.last  = (state == F_CLOSE_B) || !hold.final_rec;
    if (overflow) begin
      close_cmd.kind  = CMD_OVER;
      close_cmd.value = marker;
    end else if (count <= CNT_W'(1)) begin
      close_cmd.kind  = CMD_UNIQUE;
      close_cmd.value = first_entry.pos;
    end else begin
      close_cmd.kind  = CMD_AUX;
      close_cmd.value = row;
    end
  end

  always_comb begin
    state_next         = state;
    hold_next          = hold;
    pending_valid_next = pending_valid;
    pending_kmer_next  = pending_kmer;
    first_entry_next   = first_entry;
    count_next         = count;
    overflow_next      = overflow;
    row_next           = row;
    bank_next          = bank;
    busy_next          = busy;
    q_push             = 1'b0;
    q_cmd              = close_cmd;
    ram_we             = 1'b0;
    ram_waddr          = {bank, count[SLOT_AW-1:0]};
    ram_wdata          = hold.entry;
    do_close           = 1'b0;
    after_add          = hold.final_rec ? F_CLOSE_B : F_IDLE;

    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end

    case (state)
      F_IDLE: begin
        if (push) begin
          hold_next  = in_rec;
          state_next = (pending_valid && in_rec.kmer != pending_kmer) ? F_CLOSE_A : F_ADD;
        end
      end
      F_CLOSE_A: begin
        if (!q_full) begin
          q_push     = 1'b1;
          do_close   = 1'b1;
          state_next = F_ADD;
        end
      end
      F_ADD: begin
        if (!pending_valid) begin
          // Open a new group; hold while the bank is still being read out.
          if (!busy[bank]) begin
            ram_we             = 1'b1;
            pending_valid_next = 1'b1;
            pending_kmer_next  = hold.kmer;
            first_entry_next   = hold.entry;
            count_next         = CNT_W'(1);
            overflow_next      = 1'b0;
            state_next         = after_add;
          end
        end else if (count < CNT_W'(GROUP_SLOTS)) begin
          if (!busy[bank]) begin
            ram_we     = 1'b1;
            count_next = count + 1'b1;
            state_next = after_add;
          end
        end else begin
          // Drop the occurrence and mark the group as too large.
          overflow_next = 1'b1;
          state_next    = after_add;
        end
      end
      F_CLOSE_B: begin
        if (!q_full) begin
          q_push     = 1'b1;
          do_close   = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase

    if (do_close) begin
      pending_valid_next = 1'b0;
      count_next         = '0;
      overflow_next      = 1'b0;
      if (close_cmd.kind == CMD_AUX) begin
        busy_next[bank] = 1'b1;
        bank_next       = ~bank;
        if (row != '1) begin
          row_next = row + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      pending_valid <= 1'b0;
      pending_kmer  <= '0;
      count         <= '0;
      overflow      <= 1'b0;
      row           <= '0;
      bank          <= 1'b0;
      busy          <= '0;
      marker        <= '1;
    end else begin
      state         <= state_next;
      pending_valid <= pending_valid_next;
      pending_kmer  <= pending_kmer_next;
      count         <= count_next;
      overflow      <= overflow_next;
      row           <= row_next;
      bank          <= bank_next;
      busy          <= busy_next;
      if (cfg_we) begin
        marker <= cfg_wdata;
      end
    end
    hold        <= hold_next;
    first_entry <= first_entry_next;
  end

endmodule
`default_nettype wire

// ===== sv/skdg_back.sv =====
`default_nettype none
module skdg_back import skdg_pkg::*; #(
  parameter int GROUP_SLOTS = 10,
  localparam int SLOT_AW = $clog2(GROUP_SLOTS)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  input  wire cmd_t               q_head,
  output logic                    q_pop,
  output bank_rel_t               rel,
  output logic [SLOT_AW:0]        ram_raddr,
  input  wire logic [ENTRY_W-1:0] ram_rdata,
  input  wire logic               pop,
  output res_t                    res,
  output logic                    res_valid
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_HDR,
    B_SLOT
  } bstate_t;

  bstate_t           state, state_next;
  cmd_t              cur, cur_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [SLOT_W-1:0] rd_slot;
  res_t              res_next;
  logic              res_valid_next;
  logic              emit_ok;
  logic              advance;
  logic              used;
  logic              unique_rec;
  entry_t            rd_entry;

  assign rd_entry   = ram_rdata;
  assign emit_ok    = !res_valid || pop;
  assign used       = CNT_W'(slot) < cur.cnt;
  assign unique_rec = (cur.kind == CMD_UNIQUE);

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    slot_next      = slot;
    res_next       = res;
    res_valid_next = res_valid && !pop;
    q_pop          = 1'b0;
    rel            = '0;
    advance        = 1'b0;

    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          cur_next   = q_head;
          slot_next  = '0;
          state_next = B_HDR;
        end
      end
      B_HDR: begin
        if (emit_ok) begin
          res_valid_next           = 1'b1;
          res_next.item_kind       = ITEM_DICT;
          res_next.kmer_key        = cur.kmer;
          res_next.position_or_row = cur.value;
          res_next.is_ambiguous    = !unique_rec;
          res_next.snp             = unique_rec ? cur.first.snp : '0;
          res_next.alt             = unique_rec ? cur.first.alt : '0;
          res_next.rf              = unique_rec ? cur.first.rf : '0;
          res_next.af              = unique_rec ? cur.first.af : '0;
          res_next.slot            = '0;
          res_next.last            = cur.last && (cur.kind != CMD_AUX);
          state_next               = (cur.kind == CMD_AUX) ? B_SLOT : B_IDLE;
        end
      end
      B_SLOT: begin
        if (emit_ok) begin
          advance                  = 1'b1;
          res_valid_next           = 1'b1;
          res_next.item_kind       = ITEM_AUX;
          res_next.kmer_key        = cur.kmer;
          res_next.position_or_row = used ? rd_entry.pos : '0;
          res_next.is_ambiguous    = 1'b1;
          res_next.snp             = used ? rd_entry.snp : '0;
          res_next.alt             = used ? rd_entry.alt : '0;
          res_next.rf              = used ? rd_entry.rf : '0;
          res_next.af              = used ? rd_entry.af : '0;
          res_next.slot            = slot;
          res_next.last            = 1'b0;
          if (slot == SLOT_W'(GROUP_SLOTS - 1)) begin
            res_next.last = cur.last;
            rel.valid     = 1'b1;
            rel.bank      = cur.bank;
            state_next    = B_IDLE;
          end else begin
            slot_next = slot + 1'b1;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase

    // Read one slot ahead when this one leaves, so the data keeps pace.
    rd_slot   = advance ? slot + 1'b1 : slot;
    ram_raddr = {cur.bank, rd_slot[SLOT_AW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
    cur  <= cur_next;
    slot <= slot_next;
    res  <= res_next;
  end

endmodule
`default_nettype wire

// ===== sv/sorted_kmer_duplicate_grouper.sv =====
// Channel   Direction  Handshake              Payload
// input     in         push / full            kmer_value .. final_record, one record
// result    out        empty / pop            item_kind .. last_of_run, one result
// config    in         cfg_we                 cfg_wdata -> overflow position marker
//
// A record is accepted, closes the pending group if its k-mer differs, is stored
// (or dropped on overflow), and closes its own group if final; the front takes no
// new record until done. The back emits a dictionary record per closed group and,
// for an auxiliary row, GROUP_SLOTS entries, one per cycle while pop keeps up.
// Reset (rst, synchronous) empties the command queue and result register and loads
// the marker with all ones; the group store needs no clearing pass.
// The input stalls while the command queue is full or while the group store bank
// it must write is still being read out for an earlier auxiliary row.
`default_nettype none
module sorted_kmer_duplicate_grouper import skdg_pkg::*; #(
  parameter int GROUP_SLOTS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [KMER_W-1:0] kmer_value,
  input  wire logic [POS_W-1:0]  genome_position,
  input  wire logic [SNP_W-1:0]  variant_info,
  input  wire logic [ALT_W-1:0]  alternate_base,
  input  wire logic [FREQ_W-1:0] reference_frequency,
  input  wire logic [FREQ_W-1:0] alternate_frequency,
  input  wire logic              final_record,
  input  wire logic              cfg_we,
  input  wire logic [POS_W-1:0]  cfg_wdata,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   item_kind,
  output logic [KMER_W-1:0]      kmer_key,
  output logic [POS_W-1:0]       position_or_row,
  output logic                   is_ambiguous,
  output logic [SNP_W-1:0]       snp_field,
  output logic [ALT_W-1:0]       alt_base_out,
  output logic [FREQ_W-1:0]      ref_freq_out,
  output logic [FREQ_W-1:0]      alt_freq_out,
  output logic [SLOT_W-1:0]      slot_number,
  output logic                   last_of_run
);

  // Two banks of group storage: the front fills one while the back drains the other.
  localparam int SLOT_AW   = $clog2(GROUP_SLOTS);
  localparam int RAM_DEPTH = 2 << SLOT_AW;

  in_rec_t            in_rec;
  cmd_t               q_in;
  cmd_t               q_out;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  bank_rel_t          rel;
  logic               ram_we;
  logic [SLOT_AW:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [SLOT_AW:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  res_t               res;
  logic               res_valid;

  // Pack the request fields into one record.
  assign in_rec.kmer      = kmer_value;
  assign in_rec.entry.pos = genome_position;
  assign in_rec.entry.snp = variant_info;
  assign in_rec.entry.alt = alternate_base;
  assign in_rec.entry.rf  = reference_frequency;
  assign in_rec.entry.af  = alternate_frequency;
  assign in_rec.final_rec = final_record;

  // Front: group equal k-mers, decide how each group closes.
  skdg_front #(
    .GROUP_SLOTS(GROUP_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_rec    (in_rec),
    .full      (full),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_cmd     (q_in),
    .q_full    (q_full),
    .rel       (rel),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  // Short command queue decouples grouping from result emission.
  skdg_cmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  skdg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Back: turn each closed group into a dictionary record and its row entries.
  skdg_back #(
    .GROUP_SLOTS(GROUP_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_out),
    .q_pop     (q_pop),
    .rel       (rel),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .pop       (pop),
    .res       (res),
    .res_valid (res_valid)
  );

  assign empty           = !res_valid;
  assign item_kind       = res.item_kind;
  assign kmer_key        = res.kmer_key;
  assign position_or_row = res.position_or_row;
  assign is_ambiguous    = res.is_ambiguous;
  assign snp_field       = res.snp;
  assign alt_base_out    = res.alt;
  assign ref_freq_out    = res.rf;
  assign alt_freq_out    = res.af;
  assign slot_number     = res.slot;
  assign last_of_run     = res.last;

endmodule
`default_nettype wire

// ===== sv/skdg_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module skdg_checker import skdg_pkg::*; #(
  parameter int GROUP_SLOTS = 10
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic              item_kind,
  input wire logic [KMER_W-1:0] kmer_key,
  input wire logic [POS_W-1:0]  position_or_row,
  input wire logic              is_ambiguous,
  input wire logic [SNP_W-1:0]  snp_field,
  input wire logic [SLOT_W-1:0] slot_number,
  input wire logic              last_of_run
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(GROUP_SLOTS - 1);

  logic                  hold_res;
  logic                  dict_out;
  logic                  dict_ok;
  logic                  row_end;
  logic                  row_step;
  logic                  row_follow;
  logic [SLOT_W-1:0]     slot_expect;
  logic [KMER_W+POS_W:0] held_bits;

  // Fields that must hold while a result waits.
  assign held_bits  = {kmer_key, position_or_row, last_of_run};
  assign hold_res   = !empty && !pop;
  assign dict_out   = !empty && item_kind == ITEM_DICT;
  assign dict_ok    = slot_number == '0 && (!is_ambiguous || snp_field == '0);
  assign row_end    = !empty && item_kind == ITEM_AUX && last_of_run;
  assign row_step   = !empty && pop && item_kind == ITEM_AUX && slot_number != LAST_SLOT;
  assign row_follow = item_kind == ITEM_AUX && slot_number == slot_expect;

  // Track the slot that should follow the one shown now.
  always_ff @(posedge clk) begin
    slot_expect <= slot_number + 1'b1;
  end

  `SKDG_CHECK_RST(a_reset_empty, rst |=> empty, "results present right after reset")

  `SKDG_CHECK(a_stall_hold, hold_res |=> !empty && $stable(held_bits), "stalled result changed")

  `SKDG_CHECK(a_dict_fields, dict_out |-> dict_ok, "bad dictionary record fields")

  `SKDG_CHECK(a_row_last, row_end |-> slot_number == LAST_SLOT, "row ends before its last slot")

  `SKDG_CHECK(a_row_order, row_step |=> empty || row_follow, "row entries out of order")

endmodule

bind sorted_kmer_duplicate_grouper skdg_checker #(
  .GROUP_SLOTS(GROUP_SLOTS)
) u_skdg_checker (.*);
`default_nettype wire

// ===== tb/sv/kmer_group_tracker_pkg.sv =====
`timescale 1ns / 1ps
package kmer_group_tracker_pkg;
  import skdg_pkg::*;

  class kmer_group_tracker;
    int unsigned       slots;
    logic [POS_W-1:0]  overflow_marker;
    bit                open_group;
    logic [KMER_W-1:0] group_kmer;
    entry_t            members[16];
    int unsigned       member_count;
    bit                spilled;
    logic [POS_W-1:0]  next_row;
    res_t              grouped_records[$];
    int unsigned       mismatches;

    function new(int unsigned group_slots);
      slots = group_slots;
      overflow_marker = '1;
      open_group = 1'b0;
      group_kmer = '0;
      member_count = 0;
      spilled = 1'b0;
      next_row = '0;
      mismatches = 0;
    endfunction

    function void set_marker(logic [POS_W-1:0] value);
      overflow_marker = value;
    endfunction

    function int unsigned waiting();
      return grouped_records.size();
    endfunction

    function res_t make_result(logic kind, logic [POS_W-1:0] where, logic amb, entry_t e,
                               logic [SLOT_W-1:0] slot);
      res_t r;
      r = '0;
      r.item_kind = kind;
      r.kmer_key = group_kmer;
      r.position_or_row = where;
      r.is_ambiguous = amb;
      r.snp = e.snp;
      r.alt = e.alt;
      r.rf = e.rf;
      r.af = e.af;
      r.slot = slot;
      return r;
    endfunction

    // Close the held group: one dictionary record, plus a full auxiliary row
    // for groups of two up to the slot count.
    function void flush_group();
      logic [POS_W-1:0] row;
      entry_t           blank;
      int unsigned      j;
      blank = '0;
      if (spilled) begin
        grouped_records.push_back(make_result(ITEM_DICT, overflow_marker, 1'b1, blank, '0));
      end else if (member_count <= 1) begin
        grouped_records.push_back(make_result(ITEM_DICT, members[0].pos, 1'b0, members[0],
                                              '0));
      end else begin
        row = next_row;
        if (next_row != '1) next_row++;
        grouped_records.push_back(make_result(ITEM_DICT, row, 1'b1, blank, '0));
        for (j = 0; j < slots; j++) begin
          if (j < member_count) begin
            grouped_records.push_back(make_result(ITEM_AUX, members[j].pos, 1'b1, members[j],
                                                  j[SLOT_W-1:0]));
          end else begin
            grouped_records.push_back(make_result(ITEM_AUX, '0, 1'b1, blank, j[SLOT_W-1:0]));
          end
        end
      end
      open_group = 1'b0;
      member_count = 0;
      spilled = 1'b0;
    endfunction

    function void note_record(in_rec_t rec);
      int unsigned already;
      already = grouped_records.size();
      if (open_group && rec.kmer != group_kmer) flush_group();
      if (!open_group) begin
        open_group = 1'b1;
        group_kmer = rec.kmer;
        members[0] = rec.entry;
        member_count = 1;
        spilled = 1'b0;
      end else if (member_count < slots) begin
        members[member_count] = rec.entry;
        member_count++;
      end else begin
        spilled = 1'b1;
      end
      if (rec.final_rec) flush_group();
      if (grouped_records.size() > already) begin
        grouped_records[grouped_records.size() - 1].last = 1'b1;
      end
    endfunction

    function void compare_field(string label, logic [63:0] want_v, logic [63:0] got_v);
      if (want_v !== got_v) begin
        mismatches++;
        $display("%0t: %s expected %h, actual %h", $time, label, want_v, got_v);
      end
    endfunction

    function void check_output(res_t got);
      res_t want;
      if (grouped_records.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual kind %0d key %h value %h",
                 $time, got.item_kind, got.kmer_key, got.position_or_row);
        return;
      end
      want = grouped_records.pop_front();
      compare_field("item_kind", want.item_kind, got.item_kind);
      compare_field("kmer_key", want.kmer_key, got.kmer_key);
      compare_field("position_or_row", want.position_or_row, got.position_or_row);
      compare_field("is_ambiguous", want.is_ambiguous, got.is_ambiguous);
      compare_field("snp_field", want.snp, got.snp);
      compare_field("alt_base_out", want.alt, got.alt);
      compare_field("ref_freq_out", want.rf, got.rf);
      compare_field("alt_freq_out", want.af, got.af);
      compare_field("slot_number", want.slot, got.slot);
      compare_field("last_of_run", want.last, got.last);
    endfunction
  endclass

endpackage

// ===== tb/sv/sorted_kmer_duplicate_grouper_test.sv =====
`timescale 1ns / 1ps
module sorted_kmer_duplicate_grouper_test;
  import skdg_pkg::*;
  import kmer_group_tracker_pkg::*;

  localparam int GROUP_SLOTS = 10;
  // Cycles to let pass once every expected result is in, so the back can settle
  // before the next phase.
  localparam int SETTLE_CYCLES = 2 * GROUP_SLOTS + 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PHASE_ITEMS = 34;

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  logic [KMER_W-1:0] kmer_value;
  logic [POS_W-1:0]  genome_position;
  logic [SNP_W-1:0]  variant_info;
  logic [ALT_W-1:0]  alternate_base;
  logic [FREQ_W-1:0] reference_frequency;
  logic [FREQ_W-1:0] alternate_frequency;
  logic              final_record;
  logic              cfg_we;
  logic [POS_W-1:0]  cfg_wdata;
  logic              empty;
  logic              pop;
  logic              item_kind;
  logic [KMER_W-1:0] kmer_key;
  logic [POS_W-1:0]  position_or_row;
  logic              is_ambiguous;
  logic [SNP_W-1:0]  snp_field;
  logic [ALT_W-1:0]  alt_base_out;
  logic [FREQ_W-1:0] ref_freq_out;
  logic [FREQ_W-1:0] alt_freq_out;
  logic [SLOT_W-1:0] slot_number;
  logic              last_of_run;

  // Idle and stall rates in percent, set per phase by the main sequence.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // Cycles the receiver still holds pop low, counted down by the receiver.
  int unsigned hold_left;

  kmer_group_tracker tracker;

  sorted_kmer_duplicate_grouper #(
    .GROUP_SLOTS(GROUP_SLOTS)
  ) u_dut (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .kmer_value         (kmer_value),
    .genome_position    (genome_position),
    .variant_info       (variant_info),
    .alternate_base     (alternate_base),
    .reference_frequency(reference_frequency),
    .alternate_frequency(alternate_frequency),
    .final_record       (final_record),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .empty              (empty),
    .pop                (pop),
    .item_kind          (item_kind),
    .kmer_key           (kmer_key),
    .position_or_row    (position_or_row),
    .is_ambiguous       (is_ambiguous),
    .snp_field          (snp_field),
    .alt_base_out       (alt_base_out),
    .ref_freq_out       (ref_freq_out),
    .alt_freq_out       (alt_freq_out),
    .slot_number        (slot_number),
    .last_of_run        (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block wedges; far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Offer one request and hold it until the block takes it. Idle cycles go in
  // front of the request, so push stays high between back-to-back requests and
  // gets a single assignment per edge.
  task automatic push_record(logic [KMER_W-1:0] kmer, logic [POS_W-1:0] pos,
                             logic [SNP_W-1:0] snp, logic [ALT_W-1:0] alt,
                             logic [FREQ_W-1:0] rf, logic [FREQ_W-1:0] af, logic fin);
    in_rec_t rec;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    kmer_value <= kmer;
    genome_position <= pos;
    variant_info <= snp;
    alternate_base <= alt;
    reference_frequency <= rf;
    alternate_frequency <= af;
    final_record <= fin;
    // Values read right after the edge are the ones the edge saw.
    @(posedge clk);
    while (full) @(posedge clk);
    rec.kmer = kmer;
    rec.entry.pos = pos;
    rec.entry.snp = snp;
    rec.entry.alt = alt;
    rec.entry.rf = rf;
    rec.entry.af = af;
    rec.final_rec = fin;
    tracker.note_record(rec);
  endtask

  // Send one occurrence of a k-mer with random payload.
  task automatic send_occurrence(logic [KMER_W-1:0] kmer, logic fin);
    push_record(kmer, $urandom, $urandom_range(255), $urandom_range(3),
                $urandom_range(255), $urandom_range(255), fin);
  endtask

  // Drop push, then wait for every expected result and let the back settle.
  task automatic drain_results();
    int unsigned spent;
    push <= 1'b0;
    spent = 0;
    while (tracker.waiting() != 0 && spent < DRAIN_LIMIT) begin
      @(posedge clk);
      spent++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the marker while the block is idle, and mirror it in the tracker.
  task automatic write_marker(logic [POS_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_marker(value);
  endtask

  // Mostly sorted k-mer runs with random group sizes: singles, aux-row groups,
  // exactly full groups and overflowing ones. Mix in out-of-order k-mers and
  // early final records, sometimes followed by the same k-mer again. Close the
  // phase with a final record on a new k-mer so nothing stays held.
  task automatic run_phase(int unsigned n_items);
    logic [KMER_W-1:0] sorted_kmer;
    logic [KMER_W-1:0] run_kmer;
    int unsigned       sent;
    int unsigned       run_len;
    int unsigned       pick;
    int unsigned       i;
    bit                fin_here;
    bit                reuse;
    sorted_kmer = {$urandom, $urandom};
    run_kmer = sorted_kmer;
    sent = 0;
    reuse = 1'b0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) run_len = 1;
      else if (pick < 78) run_len = $urandom_range(GROUP_SLOTS - 1, 2);
      else if (pick < 86) run_len = GROUP_SLOTS;
      else run_len = $urandom_range(GROUP_SLOTS + 4, GROUP_SLOTS + 1);
      if (reuse) begin
        // keep run_kmer: a record after the final one starts a fresh group
        reuse = 1'b0;
      end else if ($urandom_range(99) < 8) begin
        run_kmer = {$urandom, $urandom};
      end else begin
        if ($urandom_range(3) == 0) sorted_kmer = sorted_kmer + 1;
        else sorted_kmer = sorted_kmer + 1 + {$urandom, $urandom_range(7)};
        run_kmer = sorted_kmer;
      end
      fin_here = ($urandom_range(99) < 6);
      for (i = 0; i < run_len; i++) begin
        send_occurrence(run_kmer, fin_here && (i == run_len - 1));
      end
      if (fin_here && $urandom_range(1) == 1) reuse = 1'b1;
      sent += run_len;
    end
    send_occurrence(run_kmer + 1, 1'b1);
  endtask

  // Receiver: check each accepted result, then pick pop for the next edge.
  initial begin
    res_t got;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got.item_kind = item_kind;
        got.kmer_key = kmer_key;
        got.position_or_row = position_or_row;
        got.is_ambiguous = is_ambiguous;
        got.snp = snp_field;
        got.alt = alt_base_out;
        got.rf = ref_freq_out;
        got.af = alt_freq_out;
        got.slot = slot_number;
        got.last = last_of_run;
        tracker.check_output(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int unsigned i;
    tracker = new(GROUP_SLOTS);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    rst = 1'b1;
    push = 1'b0;
    kmer_value = '0;
    genome_position = '0;
    variant_info = '0;
    alternate_base = '0;
    reference_frequency = '0;
    alternate_frequency = '0;
    final_record = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, marker still at its reset value.
    // All-zero record, then the all-ones k-mer with every field at its top.
    push_record('0, '0, '0, '0, '0, '0, 1'b0);
    push_record('1, '1, '1, '1, '1, '1, 1'b0);
    // The zero k-mer returns out of order and forms a new group of two.
    push_record('0, '1, 8'h5a, 2'd2, 8'h01, 8'hfe, 1'b0);
    push_record('0, '0, 8'ha5, 2'd1, 8'hfe, 8'h01, 1'b0);
    // Exactly full group, closed by a final record on a different k-mer:
    // the most results one request can cause.
    for (i = 0; i < GROUP_SLOTS; i++) send_occurrence(64'd5, 1'b0);
    send_occurrence(64'd6, 1'b1);
    // Same k-mer right after the final record: fresh group that overflows and
    // is closed by its own final record.
    for (i = 0; i <= GROUP_SLOTS; i++) send_occurrence(64'd6, i == GROUP_SLOTS);
    drain_results();

    // Marker at zero, no idling on either side.
    write_marker('0);
    run_phase(PHASE_ITEMS);
    drain_results();

    // Marker at all ones, sender idles often.
    write_marker('1);
    send_idle_pct = 58;
    recv_stall_pct = 0;
    run_phase(PHASE_ITEMS);
    drain_results();

    // Random marker, receiver stalls often. Hold pop off for a long stretch
    // first so the block fills up and pushes back on the sender.
    write_marker($urandom);
    send_idle_pct = 0;
    recv_stall_pct = 58;
    hold_left = 400;
    run_phase(PHASE_ITEMS);
    drain_results();

    // Both sides idle now and then.
    write_marker(32'h8000_0000);
    send_idle_pct = 31;
    recv_stall_pct = 31;
    run_phase(PHASE_ITEMS);
    drain_results();

    // Back to full rate with one more marker value.
    write_marker($urandom);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_phase(PHASE_ITEMS);
    drain_results();

    if (tracker.mismatches == 0 && tracker.waiting() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
